// ----- hw/rtl/crcfrs_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the record scanner.
// No dependencies.
package crcfrs_pkg;

  localparam int unsigned MAX_NAME_BYTES = 8;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0]  END_MARK     = 8'hff;

  // configuration register indexes
  localparam logic [1:0] CFG_MATCH_NAME  = 2'd0;
  localparam logic [1:0] CFG_NAME_LENGTH = 2'd1;
  localparam logic [1:0] CFG_MAX_VALUE   = 2'd2;

  // result kinds
  localparam logic KIND_VALUE   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // verdict codes
  localparam logic [1:0] VERDICT_FOUND     = 2'd0;
  localparam logic [1:0] VERDICT_NOT_FOUND = 2'd1;
  localparam logic [1:0] VERDICT_MISMATCH  = 2'd2;

  typedef enum logic [3:0] {
    PH_LEN     = 4'b0001,
    PH_PAYLOAD = 4'b0010,
    PH_CRC_LO  = 4'b0100,
    PH_CRC_HI  = 4'b1000
  } phase_t;

  // CRC-16, MSB first, one byte per call
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/crc_checked_field_record_scanner_unit.sv -----
// A request's result, if any, is registered and visible in the cycle after
// acceptance. One input byte per cycle when not stalled; the CRC update and
// field compare are combinational between the state and result registers.
// Input is stalled only while a result waits in the result register and the
// downstream side does not take it. Reset (rst, synchronous) clears the scan
// state and loads match_name 0, name_length 1, max_value_length 255.
module crc_checked_field_record_scanner_unit
  import crcfrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic [1:0]  verdict,
  output logic [7:0]  value_count
);

  // configuration
  logic [63:0] match_name;
  logic [3:0]  name_length;
  logic [7:0]  max_value_length;

  // scan state
  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [3:0]  name_position, name_position_next;
  logic        name_matches, name_matches_next;
  logic [7:0]  delivered, delivered_next;
  logic        value_stopped, value_stopped_next;
  logic        scan_done, scan_done_next;

  // result of the current request
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_byte;
  logic [1:0]  res_verdict;
  logic [7:0]  res_count;

  logic        have_value;
  logic        give_verdict;
  logic [1:0]  verdict_code;
  logic [3:0]  nlen;
  logic [7:0]  name_byte;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  assign nlen      = (name_length > 4'(MAX_NAME_BYTES)) ? 4'(MAX_NAME_BYTES) : name_length;
  assign name_byte = match_name[{name_position[2:0], 3'b000} +: 8];

  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    running_crc_next   = running_crc;
    crc_low_byte_next  = crc_low_byte;
    name_position_next = name_position;
    name_matches_next  = name_matches;
    delivered_next     = delivered;
    value_stopped_next = value_stopped;
    scan_done_next     = scan_done;
    have_value         = 1'b0;
    give_verdict       = 1'b0;
    verdict_code       = VERDICT_FOUND;
    res_valid          = 1'b0;
    res_kind           = KIND_VALUE;
    res_byte           = 8'h00;
    res_verdict        = VERDICT_FOUND;
    res_count          = 8'h00;

    if (!scan_done) begin
      unique case (phase)
        PH_LEN: begin
          if (in_byte == END_MARK) begin
            give_verdict = 1'b1;
            verdict_code = VERDICT_NOT_FOUND;
          end else begin
            bytes_left_next    = in_byte;
            running_crc_next   = crc_byte(16'h0000, in_byte);
            name_position_next = 4'd0;
            name_matches_next  = in_byte >= {4'b0000, nlen};
            delivered_next     = 8'h00;
            value_stopped_next = 1'b0;
            phase_next         = (in_byte == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          running_crc_next = crc_byte(running_crc, in_byte);
          if (name_position < nlen) begin
            if (name_byte != in_byte) begin
              name_matches_next = 1'b0;
            end
            name_position_next = name_position + 4'd1;
          end else if (name_matches && !value_stopped) begin
            // a zero byte ends the value and is not sent
            if (in_byte == 8'h00) begin
              value_stopped_next = 1'b1;
            end else if (delivered < max_value_length) begin
              have_value = 1'b1;
            end
          end
          bytes_left_next = bytes_left - 8'd1;
          if (bytes_left_next == 8'h00) begin
            phase_next = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          crc_low_byte_next = in_byte;
          phase_next        = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          if ({in_byte, crc_low_byte} != running_crc) begin
            give_verdict = 1'b1;
            verdict_code = VERDICT_MISMATCH;
          end else if (name_matches) begin
            give_verdict = 1'b1;
            verdict_code = VERDICT_FOUND;
          end else begin
            phase_next = PH_LEN;
          end
        end
        default: begin
          phase_next = PH_LEN;
        end
      endcase
    end

    if (give_verdict) begin
      scan_done_next = 1'b1;
    end

    if (end_of_buffer) begin
      // buffer ends without a verdict: report not found, drop any value byte
      if (!scan_done && !give_verdict) begin
        give_verdict = 1'b1;
        verdict_code = VERDICT_NOT_FOUND;
      end
      have_value = 1'b0;
    end

    if (give_verdict) begin
      res_valid   = 1'b1;
      res_kind    = KIND_VERDICT;
      res_verdict = verdict_code;
      res_count   = delivered_next;
    end else if (have_value) begin
      res_valid      = 1'b1;
      res_kind       = KIND_VALUE;
      res_byte       = in_byte;
      delivered_next = delivered_next + 8'd1;
    end

    // rearm for the next buffer
    if (end_of_buffer) begin
      phase_next         = PH_LEN;
      bytes_left_next    = 8'h00;
      running_crc_next   = 16'h0000;
      crc_low_byte_next  = 8'h00;
      name_position_next = 4'd0;
      name_matches_next  = 1'b1;
      delivered_next     = 8'h00;
      value_stopped_next = 1'b0;
      scan_done_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_name       <= 64'h0;
      name_length      <= 4'd1;
      max_value_length <= 8'hff;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MATCH_NAME:  match_name       <= cfg_data;
        CFG_NAME_LENGTH: name_length      <= cfg_data[3:0];
        CFG_MAX_VALUE:   max_value_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN;
      bytes_left    <= 8'h00;
      running_crc   <= 16'h0000;
      crc_low_byte  <= 8'h00;
      name_position <= 4'd0;
      name_matches  <= 1'b1;
      delivered     <= 8'h00;
      value_stopped <= 1'b0;
      scan_done     <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      running_crc   <= running_crc_next;
      crc_low_byte  <= crc_low_byte_next;
      name_position <= name_position_next;
      name_matches  <= name_matches_next;
      delivered     <= delivered_next;
      value_stopped <= value_stopped_next;
      scan_done     <= scan_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the payload until the result is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind    <= res_kind;
      out_byte    <= res_byte;
      verdict     <= res_verdict;
      value_count <= res_count;
    end
  end

endmodule
